// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int NCELLS    = COLUMNS * ROWS;
    localparam int LAST_ROW  = NCELLS - COLUMNS;
    localparam int CUR_W     = $clog2(NCELLS);
    localparam int PTR_W     = $clog2(NCELLS + 1);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int PC_W      = 4;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [15:0] BLANK_CELL   = 16'h0F00;
    localparam logic [15:0] CURSOR_CELL  = 16'hFF20;
    localparam logic [7:0]  NEWLINE_CODE = 8'd10;
    localparam logic [7:0]  COLOR_RESET  = 8'd15;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic REG_TEXT_COLOR = 1'b0;

    // step addresses
    localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] PC_CLR   = 4'd1;
    localparam logic [PC_W-1:0] PC_PUT   = 4'd2;
    localparam logic [PC_W-1:0] PC_MARK  = 4'd3;
    localparam logic [PC_W-1:0] PC_COPY  = 4'd4;
    localparam logic [PC_W-1:0] PC_DRAIN = 4'd5;
    localparam logic [PC_W-1:0] PC_BLANK = 4'd6;
    localparam logic [PC_W-1:0] PC_RD    = 4'd7;
    localparam logic [PC_W-1:0] PC_RDOUT = 4'd8;

    localparam logic WA_PTR    = 1'b0;
    localparam logic WA_CURSOR = 1'b1;

    localparam logic [1:0] WD_ZERO  = 2'd0;
    localparam logic [1:0] WD_PUT   = 2'd1;
    localparam logic [1:0] WD_MARK  = 2'd2;
    localparam logic [1:0] WD_BLANK = 2'd3;

    localparam logic RA_PTR  = 1'b0;
    localparam logic RA_ITEM = 1'b1;

    localparam logic [1:0] PTR_HOLD      = 2'd0;
    localparam logic [1:0] PTR_INC       = 2'd1;
    localparam logic [1:0] PTR_LOAD_COLS = 2'd2;
    localparam logic [1:0] PTR_LOAD_LAST = 2'd3;

    localparam logic [1:0] EMIT_NONE = 2'd0;
    localparam logic [1:0] EMIT_PUT  = 2'd1;
    localparam logic [1:0] EMIT_READ = 2'd2;

    localparam logic [2:0] COND_NEVER    = 3'd0;
    localparam logic [2:0] COND_ALWAYS   = 3'd1;
    localparam logic [2:0] COND_DISPATCH = 3'd2;
    localparam logic [2:0] COND_PTR_LAST = 3'd3;
    localparam logic [2:0] COND_WRAP     = 3'd4;
    localparam logic [2:0] COND_OUT_FREE = 3'd5;

    typedef struct packed {
        logic             opcode;
        logic [7:0]       char_code;
        logic [10:0]      cell_address;
    } item_in_t;

    typedef struct packed {
        logic [15:0]      read_data;
        logic [10:0]      cursor_position;
        logic             scrolled;
    } item_out_t;

    typedef struct packed {
        logic             wr_en;
        logic             wr_sel;
        logic [1:0]       wd_sel;
        logic             rd_en;
        logic             rd_sel;
        logic             copy;
        logic [1:0]       ptr_op;
        logic             cur_upd;
        logic [1:0]       emit;
        logic [2:0]       cond;
        logic             loop;
        logic [PC_W-1:0]  target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '0;
        case (pc)
            PC_IDLE:
            begin
                w.cond   = COND_DISPATCH;
                w.loop   = 1'b1;
            end
            PC_CLR:
            begin
                w.wr_en  = 1'b1;
                w.wr_sel = WA_PTR;
                w.wd_sel = WD_ZERO;
                w.ptr_op = PTR_INC;
                w.cond   = COND_PTR_LAST;
                w.loop   = 1'b1;
                w.target = PC_IDLE;
            end
            PC_PUT:
            begin
                w.wr_en   = 1'b1;
                w.wr_sel  = WA_CURSOR;
                w.wd_sel  = WD_PUT;
                w.ptr_op  = PTR_LOAD_COLS;
                w.cur_upd = 1'b1;
                w.cond    = COND_WRAP;
                w.target  = PC_COPY;
            end
            PC_MARK:
            begin
                w.wr_en  = 1'b1;
                w.wr_sel = WA_CURSOR;
                w.wd_sel = WD_MARK;
                w.emit   = EMIT_PUT;
                w.cond   = COND_OUT_FREE;
                w.loop   = 1'b1;
                w.target = PC_IDLE;
            end
            PC_COPY:
            begin
                w.rd_en  = 1'b1;
                w.rd_sel = RA_PTR;
                w.copy   = 1'b1;
                w.ptr_op = PTR_INC;
                w.cond   = COND_PTR_LAST;
                w.loop   = 1'b1;
                w.target = PC_DRAIN;
            end
            PC_DRAIN:
            begin
                w.ptr_op = PTR_LOAD_LAST;
                w.cond   = COND_NEVER;
            end
            PC_BLANK:
            begin
                w.wr_en  = 1'b1;
                w.wr_sel = WA_PTR;
                w.wd_sel = WD_BLANK;
                w.ptr_op = PTR_INC;
                w.cond   = COND_PTR_LAST;
                w.loop   = 1'b1;
                w.target = PC_MARK;
            end
            PC_RD:
            begin
                w.rd_en  = 1'b1;
                w.rd_sel = RA_ITEM;
                w.cond   = COND_NEVER;
            end
            PC_RDOUT:
            begin
                w.emit   = EMIT_READ;
                w.cond   = COND_OUT_FREE;
                w.loop   = 1'b1;
                w.target = PC_IDLE;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/text_console_writer.sv -----
// put character: the input is stalled until the put's result is emitted, so no new put
// is taken before the last is done; a put that runs past the last cell adds a scroll,
// a copy of every cell one row up (one cell a cycle) and a blank last row
// read: the input is stalled until the read's result is emitted, so reads do not overlap
// after reset the input is stalled while the cell memory is cleared;
// cursor resets to 0 and text_color to 15
module text_console_writer
    import tcw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  item_in_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output item_out_t         out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [15:0]      mem [NCELLS];

    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [CUR_W-1:0] cursor_reg, cursor_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [7:0]       color_reg;
    item_in_t         item_reg;
    logic             scrolled_reg;
    logic             copy_v_reg;
    logic [CUR_W-1:0] copy_dst_reg;
    logic [15:0]      rdata_reg;
    logic             out_valid_reg, out_valid_next;
    item_out_t        out_data_reg;

    ucode_t           uc;
    logic             in_fire;
    logic             out_free;
    logic             newline;
    logic             wrap;
    logic             take;
    logic [PC_W-1:0]  target;
    logic             mem_we;
    logic [CUR_W-1:0] waddr;
    logic [15:0]      wdata;
    logic [CUR_W-1:0] raddr;
    logic             rd_ok;

    assign uc       = ucode_rom(pc_reg);
    assign in_stall = (pc_reg != PC_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign newline  = (item_reg.char_code == NEWLINE_CODE);
    assign rd_ok    = (item_reg.cell_address < 11'(NCELLS));

    always_comb
    begin
        if (newline)
            wrap = (cursor_reg >= CUR_W'(LAST_ROW));
        else
            wrap = (cursor_reg == CUR_W'(NCELLS - 1));
    end

    // sequencer
    always_comb
    begin
        target = uc.target;
        case (uc.cond)
            COND_NEVER:    take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_DISPATCH:
            begin
                take   = in_fire;
                target = (in_data.opcode == OP_READ) ? PC_RD : PC_PUT;
            end
            COND_PTR_LAST: take = (ptr_reg == PTR_W'(NCELLS - 1));
            COND_WRAP:     take = wrap;
            COND_OUT_FREE: take = out_free;
            default:       take = 1'b1;
        endcase
        if (take)
            pc_next = target;
        else if (uc.loop)
            pc_next = pc_reg;
        else
            pc_next = pc_reg + 1'b1;
    end

    always_comb
    begin
        case (uc.ptr_op)
            PTR_HOLD:      ptr_next = ptr_reg;
            PTR_INC:       ptr_next = ptr_reg + 1'b1;
            PTR_LOAD_COLS: ptr_next = PTR_W'(COLUMNS);
            PTR_LOAD_LAST: ptr_next = PTR_W'(LAST_ROW);
            default:       ptr_next = ptr_reg;
        endcase
    end

    // cursor advance
    always_comb
    begin
        cursor_next = cursor_reg;
        col_next    = col_reg;
        if (uc.cur_upd)
        begin
            if (wrap)
            begin
                cursor_next = CUR_W'(LAST_ROW);
                col_next    = '0;
            end
            else if (newline)
            begin
                cursor_next = cursor_reg - CUR_W'(col_reg) + CUR_W'(COLUMNS);
                col_next    = '0;
            end
            else
            begin
                cursor_next = cursor_reg + 1'b1;
                col_next    = (col_reg == COL_W'(COLUMNS - 1)) ? '0 : col_reg + 1'b1;
            end
        end
    end

    // memory port selection, pending copy write has priority
    always_comb
    begin
        if (copy_v_reg)
        begin
            mem_we = 1'b1;
            waddr  = copy_dst_reg;
            wdata  = rdata_reg;
        end
        else
        begin
            mem_we = uc.wr_en;
            waddr  = (uc.wr_sel == WA_CURSOR) ? cursor_reg : ptr_reg[CUR_W-1:0];
            case (uc.wd_sel)
                WD_ZERO:  wdata = '0;
                WD_PUT:   wdata = newline ? BLANK_CELL : {color_reg, item_reg.char_code};
                WD_MARK:  wdata = CURSOR_CELL;
                WD_BLANK: wdata = BLANK_CELL;
                default:  wdata = '0;
            endcase
        end
        raddr = (uc.rd_sel == RA_ITEM) ? CUR_W'(item_reg.cell_address) : ptr_reg[CUR_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        if (uc.rd_en)
            rdata_reg <= mem[raddr];
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (uc.emit != EMIT_NONE && out_free)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (uc.emit != EMIT_NONE && out_free)
        begin
            out_data_reg.cursor_position <= 11'(cursor_reg);
            if (uc.emit == EMIT_READ)
            begin
                out_data_reg.read_data <= rd_ok ? rdata_reg : 16'd0;
                out_data_reg.scrolled  <= 1'b0;
            end
            else
            begin
                out_data_reg.read_data <= 16'd0;
                out_data_reg.scrolled  <= scrolled_reg;
            end
        end
        if (in_fire)
            item_reg <= in_data;
        if (uc.cur_upd)
            scrolled_reg <= wrap;
        copy_dst_reg <= ptr_reg[CUR_W-1:0] - CUR_W'(COLUMNS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_CLR;
            ptr_reg       <= '0;
            cursor_reg    <= '0;
            col_reg       <= '0;
            copy_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            color_reg     <= COLOR_RESET;
        end
        else
        begin
            pc_reg        <= pc_next;
            ptr_reg       <= ptr_next;
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            copy_v_reg    <= uc.copy;
            out_valid_reg <= out_valid_next;
            if (psel && penable && pwrite && pready && paddr[2] == REG_TEXT_COLOR)
                color_reg <= pwdata[7:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_TEXT_COLOR) ? {24'd0, color_reg} : '0;

    // copy writes never collide with a sequencer write
    assert property (@(posedge clk) disable iff (!rst_n) copy_v_reg |-> !uc.wr_en)
        else $error("copy write collides with control write");

    assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg < CUR_W'(NCELLS))
        else $error("cursor out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < COL_W'(COLUMNS))
        else $error("column tracker out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(pc_reg) == PC_MARK || $past(pc_reg) == PC_RDOUT))
        else $error("result raised outside an emit step");

endmodule
